// ===== sv/tqs_pkg.sv =====
// Shared types and constants for the task ready-queue scheduler.
// Beat payload structs, operation and task-state codes. No dependencies.
package tqs_pkg;

   localparam int OP_W        = 3;
   localparam int TASK_ID_W   = 3;
   localparam int STATE_W     = 3;
   localparam int LIVE_W      = 4;
   localparam int READY_CNT_W = 6;
   localparam int TICK_W      = 32;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE   = 3'd0,
      OP_DELETE   = 3'd1,
      OP_DISPATCH = 3'd2,
      OP_YIELD    = 3'd3,
      OP_TERMINATE = 3'd4,
      OP_BLOCK    = 3'd5,
      OP_SUSPEND  = 3'd6,
      OP_RESUME   = 3'd7
   } op_type;

   typedef enum logic [STATE_W-1:0] {
      TASK_FREE    = 3'd0,
      TASK_READY   = 3'd1,
      TASK_RUN     = 3'd2,
      TASK_BLOCKED = 3'd3,
      TASK_STOPPED = 3'd4
   } task_state_type;

   typedef struct packed {
      logic [OP_W-1:0]      op;
      logic [TASK_ID_W-1:0] task_id;
   } req_payload_type;

   typedef struct packed {
      logic [TASK_ID_W-1:0]   dispatched_task;
      logic                   dispatched;
      logic [TASK_ID_W-1:0]   running_task;
      logic                   running_valid;
      logic [STATE_W-1:0]     addressed_state;
      logic [READY_CNT_W-1:0] ready_count;
      logic [LIVE_W-1:0]      active_tasks;
      logic [TICK_W-1:0]      tick_count;
      logic                   queue_overflow;
   } rsp_payload_type;

endpackage

// ===== sv/tqs_chan_if.sv =====
// Valid/ready channel carrying one payload per beat.
// Payload type is a parameter; normally a struct from tqs_pkg.
interface tqs_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/tqs_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module tqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== sv/task_ready_queue_scheduler_unit.sv =====
// Task ready-queue scheduler: per-task state RAM plus ring-buffer ready queue RAM.
// Depends on tqs_pkg, tqs_chan_if and tqs_ram.
//
//   channel    dir   payload                          beat
//   req_chan   in    op, task_id                      valid & ready
//   rsp_chan   out   dispatched_task .. overflow      valid & ready
//
// Create, suspend, resume, yield, terminate, block: S_LOOK, then S_FIN and S_FINW.
// Dispatch: S_POP, S_POPV, S_POPS per queue entry popped, until a ready task or an empty queue.
// Delete: S_LOOK, then S_PURGE_RD and S_PURGE_WR per queue entry, a read-compare-write walk
// over the read and write ports of the queue RAM.
// Reset is synchronous; clears control state and the task-state valid bits.
// A new item is taken while the previous result waits in the output register;
// a full output register holds the block in its final cycle.
module task_ready_queue_scheduler_unit #(
   parameter int NUM_TASKS   = 8,
   parameter int QUEUE_DEPTH = 32
) (
   input logic clock,
   input logic reset,
   tqs_chan_if.sink   req_chan,
   tqs_chan_if.source rsp_chan
);
   localparam int TID_W  = tqs_pkg::TASK_ID_W;
   localparam int TIDX_W = $clog2(NUM_TASKS);
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_LOOK     = 9'b000000010,
      S_POP      = 9'b000000100,
      S_POPV     = 9'b000001000,
      S_POPS     = 9'b000010000,
      S_PURGE_RD = 9'b000100000,
      S_PURGE_WR = 9'b001000000,
      S_FIN      = 9'b010000000,
      S_FINW     = 9'b100000000
   } fsm_type;

   function automatic logic [TIDX_W-1:0] to_idx(input logic [TID_W-1:0] t);
      logic [TIDX_W+TID_W-1:0] w;
      begin
         w = {{TIDX_W{1'b0}}, t};
         return w[TIDX_W-1:0];
      end
   endfunction

   function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
      begin
         return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
      end
   endfunction

   fsm_type                      state_ff, state_in;
   tqs_pkg::op_type              op_ff, op_in;
   logic [TID_W-1:0]             tid_ff, tid_in;
   logic                         tok_ff, tok_in;
   logic [QPTR_W-1:0]            head_ff, head_in;
   logic [QCNT_W-1:0]            count_ff, count_in;
   logic [TID_W-1:0]             cur_ff, cur_in;
   logic                         cur_valid_ff, cur_valid_in;
   logic [tqs_pkg::LIVE_W-1:0]   live_ff, live_in;
   logic [tqs_pkg::TICK_W-1:0]   ticks_ff, ticks_in;
   logic                         found_ff, found_in;
   logic [TID_W-1:0]             chosen_ff, chosen_in;
   logic                         ovf_ff, ovf_in;
   logic [QPTR_W-1:0]            prd_ff, prd_in;
   logic [QPTR_W-1:0]            pwr_ff, pwr_in;
   logic [QCNT_W-1:0]            pleft_ff, pleft_in;
   logic [QCNT_W-1:0]            kept_ff, kept_in;
   logic [TID_W-1:0]             pop_v_ff, pop_v_in;
   logic [NUM_TASKS-1:0]         st_valid_ff;
   logic                         st_rd_valid_ff, st_rd_valid_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   tqs_pkg::rsp_payload_type     rsp_data_ff, rsp_data_in;

   logic                         st_we, st_re;
   logic [TIDX_W-1:0]            st_waddr, st_raddr;
   logic [tqs_pkg::STATE_W-1:0]  st_wdata, st_rdata, sd;
   logic                         q_we, q_re;
   logic [QPTR_W-1:0]            q_waddr, q_raddr;
   logic [TID_W-1:0]             q_wdata, q_rdata;

   logic                         do_push;
   logic [TID_W-1:0]             push_id;
   logic                         rsp_load;
   logic                         req_beat;
   logic                         q_full;
   logic [QCNT_W:0]              tail_sum, tail_wide;
   logic [QPTR_W-1:0]            tail_ptr;
   logic [QCNT_W+tqs_pkg::READY_CNT_W-1:0] cnt_wide;

   tqs_ram #(.WIDTH(tqs_pkg::STATE_W), .DEPTH(NUM_TASKS)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (st_re),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   tqs_ram #(.WIDTH(TID_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_en   (q_re),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   assign req_beat  = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   // never-written entries read as free
   assign sd = st_rd_valid_ff ? st_rdata : tqs_pkg::TASK_FREE;

   assign q_full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign tail_sum  = {{(QCNT_W + 1 - QPTR_W){1'b0}}, head_ff} + {1'b0, count_ff};
   assign tail_wide = (tail_sum >= (QCNT_W + 1)'(QUEUE_DEPTH)) ?
                      tail_sum - (QCNT_W + 1)'(QUEUE_DEPTH) : tail_sum;
   assign tail_ptr  = tail_wide[QPTR_W-1:0];
   assign cnt_wide  = {{tqs_pkg::READY_CNT_W{1'b0}}, count_ff};

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      tid_in       = tid_ff;
      tok_in       = tok_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      live_in      = live_ff;
      ticks_in     = ticks_ff;
      found_in     = found_ff;
      chosen_in    = chosen_ff;
      ovf_in       = ovf_ff;
      prd_in       = prd_ff;
      pwr_in       = pwr_ff;
      pleft_in     = pleft_ff;
      kept_in      = kept_ff;
      pop_v_in     = pop_v_ff;
      st_rd_valid_in = st_rd_valid_ff;
      st_we    = 1'b0;
      st_waddr = '0;
      st_wdata = tqs_pkg::TASK_FREE;
      st_re    = 1'b0;
      st_raddr = '0;
      q_we     = 1'b0;
      q_waddr  = '0;
      q_wdata  = '0;
      q_re     = 1'b0;
      q_raddr  = '0;
      do_push  = 1'b0;
      push_id  = '0;
      rsp_load = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               op_in     = tqs_pkg::op_type'(req_chan.payload.op);
               tid_in    = req_chan.payload.task_id;
               tok_in    = int'(req_chan.payload.task_id) < NUM_TASKS;
               found_in  = 1'b0;
               chosen_in = '0;
               ovf_in    = 1'b0;
               if (req_chan.payload.op == tqs_pkg::OP_DISPATCH) begin
                  ticks_in = ticks_ff + 1'b1;
                  state_in = S_POP;
               end else begin
                  st_re = 1'b1;
                  if (req_chan.payload.op == tqs_pkg::OP_YIELD ||
                      req_chan.payload.op == tqs_pkg::OP_TERMINATE ||
                      req_chan.payload.op == tqs_pkg::OP_BLOCK) begin
                     st_raddr = to_idx(cur_ff);
                  end else begin
                     st_raddr = to_idx(req_chan.payload.task_id);
                  end
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            state_in = S_FIN;
            st_waddr = to_idx(tid_ff);
            unique case (op_ff)
               tqs_pkg::OP_CREATE: begin
                  if (tok_ff && sd == tqs_pkg::TASK_FREE) begin
                     st_we    = 1'b1;
                     st_wdata = tqs_pkg::TASK_READY;
                     live_in  = live_ff + 1'b1;
                     do_push  = 1'b1;
                     push_id  = tid_ff;
                  end
               end
               tqs_pkg::OP_DELETE: begin
                  if (tok_ff && sd != tqs_pkg::TASK_FREE) begin
                     st_we    = 1'b1;
                     st_wdata = tqs_pkg::TASK_FREE;
                     if (live_ff != '0) begin
                        live_in = live_ff - 1'b1;
                     end
                     if (cur_valid_ff && cur_ff == tid_ff) begin
                        cur_valid_in = 1'b0;
                     end
                     prd_in   = head_ff;
                     pwr_in   = head_ff;
                     pleft_in = count_ff;
                     kept_in  = '0;
                     state_in = S_PURGE_RD;
                  end
               end
               tqs_pkg::OP_DISPATCH: begin
               end
               tqs_pkg::OP_YIELD: begin
                  if (cur_valid_ff) begin
                     if (sd == tqs_pkg::TASK_RUN) begin
                        st_we    = 1'b1;
                        st_waddr = to_idx(cur_ff);
                        st_wdata = tqs_pkg::TASK_READY;
                        do_push  = 1'b1;
                        push_id  = cur_ff;
                     end
                     cur_valid_in = 1'b0;
                  end
               end
               tqs_pkg::OP_TERMINATE, tqs_pkg::OP_BLOCK: begin
                  if (cur_valid_ff) begin
                     st_we    = 1'b1;
                     st_waddr = to_idx(cur_ff);
                     st_wdata = (op_ff == tqs_pkg::OP_TERMINATE) ?
                                tqs_pkg::TASK_STOPPED : tqs_pkg::TASK_BLOCKED;
                     cur_valid_in = 1'b0;
                  end
               end
               tqs_pkg::OP_SUSPEND: begin
                  if (tok_ff && (sd == tqs_pkg::TASK_RUN || sd == tqs_pkg::TASK_READY)) begin
                     st_we    = 1'b1;
                     st_wdata = tqs_pkg::TASK_BLOCKED;
                  end
               end
               tqs_pkg::OP_RESUME: begin
                  if (tok_ff && sd == tqs_pkg::TASK_BLOCKED) begin
                     st_we    = 1'b1;
                     st_wdata = tqs_pkg::TASK_READY;
                     do_push  = 1'b1;
                     push_id  = tid_ff;
                  end
               end
            endcase
            if (do_push) begin
               if (q_full) begin
                  ovf_in = 1'b1;
               end else begin
                  q_we     = 1'b1;
                  q_waddr  = tail_ptr;
                  q_wdata  = push_id;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         S_POP: begin
            if (count_ff == '0) begin
               cur_valid_in = 1'b0;
               state_in     = S_FIN;
            end else begin
               q_re     = 1'b1;
               q_raddr  = head_ff;
               head_in  = ptr_inc(head_ff);
               count_in = count_ff - 1'b1;
               state_in = S_POPV;
            end
         end
         S_POPV: begin
            pop_v_in = q_rdata;
            if (int'(q_rdata) < NUM_TASKS) begin
               st_re    = 1'b1;
               st_raddr = to_idx(q_rdata);
               state_in = S_POPS;
            end else begin
               state_in = S_POP;
            end
         end
         S_POPS: begin
            if (sd == tqs_pkg::TASK_READY) begin
               st_we        = 1'b1;
               st_waddr     = to_idx(pop_v_ff);
               st_wdata     = tqs_pkg::TASK_RUN;
               cur_in       = pop_v_ff;
               cur_valid_in = 1'b1;
               found_in     = 1'b1;
               chosen_in    = pop_v_ff;
               state_in     = S_FIN;
            end else begin
               state_in = S_POP;
            end
         end
         S_PURGE_RD: begin
            if (pleft_ff == '0) begin
               count_in = kept_ff;
               state_in = S_FIN;
            end else begin
               q_re     = 1'b1;
               q_raddr  = prd_ff;
               prd_in   = ptr_inc(prd_ff);
               pleft_in = pleft_ff - 1'b1;
               state_in = S_PURGE_WR;
            end
         end
         S_PURGE_WR: begin
            if (q_rdata != tid_ff) begin
               q_we    = 1'b1;
               q_waddr = pwr_ff;
               q_wdata = q_rdata;
               pwr_in  = ptr_inc(pwr_ff);
               kept_in = kept_ff + 1'b1;
            end
            state_in = S_PURGE_RD;
         end
         S_FIN: begin
            st_re    = 1'b1;
            st_raddr = to_idx(tid_ff);
            state_in = S_FINW;
         end
         S_FINW: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (st_re) begin
         st_rd_valid_in = st_valid_ff[st_raddr];
      end
   end

   always_comb begin
      rsp_data_in                 = rsp_data_ff;
      rsp_valid_in                = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in                    = 1'b1;
         rsp_data_in.dispatched_task     = found_ff ? chosen_ff : '0;
         rsp_data_in.dispatched          = found_ff;
         rsp_data_in.running_task        = cur_valid_ff ? cur_ff : '0;
         rsp_data_in.running_valid       = cur_valid_ff;
         rsp_data_in.addressed_state     = tok_ff ? sd : '0;
         rsp_data_in.ready_count         = cnt_wide[tqs_pkg::READY_CNT_W-1:0];
         rsp_data_in.active_tasks        = live_ff;
         rsp_data_in.tick_count          = ticks_ff;
         rsp_data_in.queue_overflow      = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         cur_ff       <= '0;
         cur_valid_ff <= 1'b0;
         live_ff      <= '0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         st_valid_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         cur_valid_ff <= cur_valid_in;
         live_ff      <= live_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
         if (st_we) begin
            st_valid_ff[st_waddr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      tid_ff         <= tid_in;
      tok_ff         <= tok_in;
      found_ff       <= found_in;
      chosen_ff      <= chosen_in;
      ovf_ff         <= ovf_in;
      prd_ff         <= prd_in;
      pwr_ff         <= pwr_in;
      pleft_ff       <= pleft_in;
      kept_ff        <= kept_in;
      pop_v_ff       <= pop_v_in;
      st_rd_valid_ff <= st_rd_valid_in;
      rsp_data_ff    <= rsp_data_in;
   end
endmodule

// ===== sv/tqs_checker.sv =====
// Port-level checks for the task ready-queue scheduler, bound to its top level.
// Depends on task_ready_queue_scheduler_unit and tqs_pkg field widths.
module tqs_checker #(
   parameter int QUEUE_DEPTH = 32
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  dispatched_task,
   input logic        dispatched,
   input logic [2:0]  running_task,
   input logic        running_valid,
   input logic [5:0]  ready_count,
   input logic [3:0]  active_tasks,
   input logic        queue_overflow
);
   localparam logic [5:0] FullCount = 6'(QUEUE_DEPTH % 64);

   // beat held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(dispatched_task) &&
      $stable(running_task) && $stable(ready_count))
      else $error("rsp beat changed while stalled");

   a_dispatch_runs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dispatched |-> running_valid && running_task == dispatched_task)
      else $error("dispatched task is not the running one");

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (running_valid || running_task == 3'd0) &&
                    (dispatched || dispatched_task == 3'd0))
      else $error("task number shown without its valid flag");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && queue_overflow |-> ready_count == FullCount && !dispatched)
      else $error("overflow flagged with queue not full");

   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> active_tasks <= 4'd8)
      else $error("more live tasks than task numbers");
endmodule

bind task_ready_queue_scheduler_unit tqs_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_tqs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .dispatched_task (rsp_chan.payload.dispatched_task),
   .dispatched      (rsp_chan.payload.dispatched),
   .running_task    (rsp_chan.payload.running_task),
   .running_valid   (rsp_chan.payload.running_valid),
   .ready_count     (rsp_chan.payload.ready_count),
   .active_tasks    (rsp_chan.payload.active_tasks),
   .queue_overflow  (rsp_chan.payload.queue_overflow)
);

// ===== dv/tqs_sched_check_pkg.sv =====
// Scoreboard for the task ready-queue scheduler testbench: a software copy of the
// task table and ready queue that predicts each response beat and checks it.
// Depends on tqs_pkg.
package tqs_sched_check_pkg;
   import tqs_pkg::*;

   localparam int TASKS        = 8;
   localparam int DEPTH        = 32;

   class sched_scoreboard;
      task_state_type  task_state[TASKS];
      logic [2:0]      ready_queue[$];
      logic [2:0]      cur_task;
      bit              cur_valid;
      int unsigned     live;
      logic [31:0]     ticks;
      rsp_payload_type pending_rsp[$];
      int              errors;

      function new();
         foreach (task_state[i]) task_state[i] = TASK_FREE;
         cur_task  = '0;
         cur_valid = 1'b0;
         live      = 0;
         ticks     = '0;
         errors    = 0;
      endfunction

      function bit enqueue(logic [2:0] t);
         if (ready_queue.size() >= DEPTH) return 1'b0;
         ready_queue.push_back(t);
         return 1'b1;
      endfunction

      // Advance the copy by one request beat and queue the response it should give.
      function void apply_request(req_payload_type r);
         logic [2:0]      t;
         logic [2:0]      v;
         logic [2:0]      chosen;
         logic [2:0]      kept[$];
         bit              t_ok;
         bit              found;
         bit              overflow;
         rsp_payload_type e;
         t        = r.task_id;
         t_ok     = int'(t) < TASKS;
         found    = 1'b0;
         overflow = 1'b0;
         chosen   = '0;
         case (op_type'(r.op))
            OP_CREATE: begin
               if (t_ok && task_state[t] == TASK_FREE) begin
                  task_state[t] = TASK_READY;
                  live++;
                  if (!enqueue(t)) overflow = 1'b1;
               end
            end
            OP_DELETE: begin
               if (t_ok && task_state[t] != TASK_FREE) begin
                  if (live > 0) live--;
                  foreach (ready_queue[i]) if (ready_queue[i] != t) kept.push_back(ready_queue[i]);
                  ready_queue   = kept;
                  task_state[t] = TASK_FREE;
                  if (cur_valid && cur_task == t) cur_valid = 1'b0;
               end
            end
            OP_DISPATCH: begin
               ticks = ticks + 32'd1;
               while (ready_queue.size() > 0 && !found) begin
                  v = ready_queue.pop_front();
                  if (int'(v) < TASKS && task_state[v] == TASK_READY) begin
                     found  = 1'b1;
                     chosen = v;
                  end
               end
               if (found) begin
                  task_state[chosen] = TASK_RUN;
                  cur_task           = chosen;
                  cur_valid          = 1'b1;
               end else begin
                  cur_valid = 1'b0;
               end
            end
            OP_YIELD: begin
               if (cur_valid && int'(cur_task) < TASKS) begin
                  if (task_state[cur_task] == TASK_RUN) begin
                     task_state[cur_task] = TASK_READY;
                     if (!enqueue(cur_task)) overflow = 1'b1;
                  end
                  cur_valid = 1'b0;
               end
            end
            OP_TERMINATE: begin
               if (cur_valid && int'(cur_task) < TASKS) begin
                  task_state[cur_task] = TASK_STOPPED;
                  cur_valid            = 1'b0;
               end
            end
            OP_BLOCK: begin
               if (cur_valid && int'(cur_task) < TASKS) begin
                  task_state[cur_task] = TASK_BLOCKED;
                  cur_valid            = 1'b0;
               end
            end
            OP_SUSPEND: begin
               if (t_ok && (task_state[t] == TASK_RUN || task_state[t] == TASK_READY))
                  task_state[t] = TASK_BLOCKED;
            end
            OP_RESUME: begin
               if (t_ok && task_state[t] == TASK_BLOCKED) begin
                  task_state[t] = TASK_READY;
                  if (!enqueue(t)) overflow = 1'b1;
               end
            end
            default: ;
         endcase
         e.dispatched_task = found ? chosen : 3'd0;
         e.dispatched      = found;
         e.running_task    = cur_valid ? cur_task : 3'd0;
         e.running_valid   = cur_valid;
         e.addressed_state = t_ok ? task_state[t] : TASK_FREE;
         e.ready_count     = READY_CNT_W'(ready_queue.size());
         e.active_tasks    = LIVE_W'(live);
         e.tick_count      = ticks;
         e.queue_overflow  = overflow;
         pending_rsp.push_back(e);
      endfunction

      function void compare_field(string name, logic [31:0] exp, logic [31:0] got,
                                  realtime at);
         if (got !== exp) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", at, name, exp, got);
         end
      endfunction

      function void check_result(rsp_payload_type got, realtime at);
         rsp_payload_type e;
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t ns: response beat with nothing expected, actual %h", at, got);
            return;
         end
         e = pending_rsp.pop_front();
         compare_field("dispatched_task", 32'(e.dispatched_task), 32'(got.dispatched_task), at);
         compare_field("dispatched",      32'(e.dispatched),      32'(got.dispatched), at);
         compare_field("running_task",    32'(e.running_task),    32'(got.running_task), at);
         compare_field("running_valid",   32'(e.running_valid),   32'(got.running_valid), at);
         compare_field("addressed_state", 32'(e.addressed_state), 32'(got.addressed_state), at);
         compare_field("ready_count",     32'(e.ready_count),     32'(got.ready_count), at);
         compare_field("active_tasks",    32'(e.active_tasks),    32'(got.active_tasks), at);
         compare_field("tick_count",      e.tick_count,           got.tick_count, at);
         compare_field("queue_overflow",  32'(e.queue_overflow),  32'(got.queue_overflow), at);
      endfunction
   endclass

endpackage

// ===== dv/task_ready_queue_scheduler_unit_test.sv =====
// Top-level testbench for task_ready_queue_scheduler_unit: directed and random
// scheduler operations under four idle/stall phases, checked by the scoreboard.
// Depends on tqs_pkg, tqs_chan_if and tqs_sched_check_pkg.
module task_ready_queue_scheduler_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tqs_pkg::*;
   import tqs_sched_check_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int ITEMS_PER_PHASE = 232;
   localparam int DRAIN_CYCLES    = 150;

   logic            clock;
   logic            reset;
   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;
   int              cycles         = 0;
   int              items_sent     = 0;
   sched_scoreboard sb;

   tqs_chan_if #(.payload_type(req_payload_type)) req_chan ();
   tqs_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   task_ready_queue_scheduler_unit #(
      .NUM_TASKS   (TASKS),
      .QUEUE_DEPTH (DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL task_ready_queue_scheduler_unit");
         $finish;
      end
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
         sb.check_result(rsp_chan.payload, $realtime);
   end

   function automatic logic [2:0] any_id();
      return 3'($urandom_range(0, TASKS - 1));
   endfunction

   function automatic logic [2:0] live_id();
      logic [2:0] ids[$];
      for (int i = 0; i < TASKS; i++) if (sb.task_state[i] != TASK_FREE) ids.push_back(3'(i));
      if (ids.size() == 0) return any_id();
      return ids[$urandom_range(0, ids.size() - 1)];
   endfunction

   // Called at a falling edge; returns at a falling edge with valid still high
   // unless the sender goes idle.
   task automatic send_item(op_type op, logic [2:0] id);
      req_payload_type p;
      int              gap;
      p.op             = op;
      p.task_id        = id;
      req_chan.valid   <= 1'b1;
      req_chan.payload <= p;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      sb.apply_request(p);
      items_sent++;
      @(negedge clock);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         gap = $urandom_range(1, 4);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic directed_items();
      send_item(OP_DISPATCH,  3'd0);   // empty queue
      send_item(OP_YIELD,     3'd7);   // nothing running
      send_item(OP_TERMINATE, 3'd0);
      send_item(OP_BLOCK,     3'd0);
      send_item(OP_DELETE,    3'd5);   // free task
      send_item(OP_SUSPEND,   3'd6);
      send_item(OP_RESUME,    3'd6);
      send_item(OP_CREATE,    3'd0);
      send_item(OP_CREATE,    3'd7);
      send_item(OP_CREATE,    3'd0);   // already in use
      send_item(OP_CREATE,    3'd5);
      send_item(OP_DISPATCH,  3'd0);
      send_item(OP_SUSPEND,   3'd0);   // running task blocked, stays current
      send_item(OP_YIELD,     3'd0);   // gives up without requeue
      send_item(OP_RESUME,    3'd0);
      send_item(OP_SUSPEND,   3'd7);   // leaves a stale entry
      send_item(OP_DISPATCH,  3'd0);   // skips the stale entry
      send_item(OP_DISPATCH,  3'd0);   // replaces the running task
      send_item(OP_RESUME,    3'd7);
      send_item(OP_YIELD,     3'd0);
      send_item(OP_DELETE,    3'd7);   // compacts the queue
      send_item(OP_DISPATCH,  3'd0);
      send_item(OP_BLOCK,     3'd0);
      send_item(OP_DELETE,    3'd5);   // task in run but not current
      send_item(OP_DISPATCH,  3'd0);   // finds nothing
   endtask

   task automatic random_burst();
      int         pick;
      int         n;
      logic [2:0] t;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         send_item(op_type'($urandom_range(0, 7)), any_id());
      end else if (pick < 22) begin
         send_item(OP_CREATE, any_id());
      end else if (pick < 30) begin
         send_item(OP_DELETE, ($urandom_range(0, 1) != 0) ? live_id() : any_id());
      end else if (pick < 60) begin
         send_item(OP_DISPATCH, any_id());
         pick = $urandom_range(0, 99);
         if (pick < 35)      send_item(OP_YIELD, any_id());
         else if (pick < 50) send_item(OP_BLOCK, any_id());
         else if (pick < 60) send_item(OP_TERMINATE, any_id());
         else if (pick < 70) send_item(OP_SUSPEND, sb.cur_task);
         else if (pick < 78) send_item(OP_DELETE, sb.cur_task);
      end else if (pick < 85) begin
         // suspend/resume pairs grow the queue towards full
         t = live_id();
         n = $urandom_range(1, 12);
         repeat (n) begin
            send_item(OP_SUSPEND, t);
            send_item(OP_RESUME, t);
         end
      end else begin
         send_item(($urandom_range(0, 1) != 0) ? OP_RESUME : OP_SUSPEND, live_id());
      end
   endtask

   initial begin
      int target;
      sb               = new();
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      directed_items();
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
            default: begin send_idle_pct = 37; recv_stall_pct = 37; end
         endcase
         target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < target) random_burst();
      end
      req_chan.valid <= 1'b0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("PASS task_ready_queue_scheduler_unit");
      else
         $display("FAIL task_ready_queue_scheduler_unit");
      $finish;
   end

endmodule

// ===== task_ready_queue_scheduler_unit.f =====
sv/tqs_pkg.sv
sv/tqs_chan_if.sv
sv/tqs_ram.sv
sv/task_ready_queue_scheduler_unit.sv
sv/tqs_checker.sv
dv/tqs_sched_check_pkg.sv
dv/task_ready_queue_scheduler_unit_test.sv
